// ----- src/ffba_pkg.sv -----
package ffba_pkg;

    localparam int ARENA_BYTES_DEF  = 65536;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int MIN_REMAINDER    = 8;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ZERO   = 2'd1,
        ST_NOFIT  = 2'd2
    } status_t;

    typedef struct packed {
        logic        action;
        logic [15:0] request_bytes;
        logic [15:0] payload_offset;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] grant_offset;
        logic [1:0]  status;
    } out_beat_t;

    // fields of a tag are below_free, below_len, is_free, len, fwd nil+17b, back nil+17b
    typedef struct packed {
        logic        below_free;
        logic [16:0] below_len;
        logic        is_free;
        logic [16:0] len;
        logic        fwd_nil;
        logic [16:0] fwd;
        logic        back_nil;
        logic [16:0] back;
    } tag_t;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DEC,
        S_RD, S_WAIT, S_CHK,
        S_CARVE0, S_CARVE1, S_CARVE2, S_CARVE3, S_CARVE4,
        S_UNL0, S_UNL1, S_UNL2, S_UNL3,
        S_MARK0, S_MARK1, S_MARK2, S_MARK3,
        S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5, S_FR6,
        S_OUT
    } fsm_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_INIT0, OP_INIT1, OP_LOAD, OP_RDCUR, OP_LATCH, OP_NEXT,
        OP_CARVE_O, OP_CARVE_U, OP_RD_A, OP_WR_A_BLEN,
        OP_UNLINK, OP_RD_TAKEN, OP_MARK, OP_FREE, OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] sub;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic zero_req;
        logic free_ok_addr;
        logic cur_valid;
        logic walk_over;
        logic fits;
        logic split;
        logic tag_free;
        logic a_in;
        logic f_in;
        logic b_in;
        logic head_in;
    } sts_t;

endpackage

// ----- src/ffba_ctrl.sv -----
module ffba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output ffba_pkg::cmd_t cmd,
    input  ffba_pkg::sts_t sts
);
    import ffba_pkg::*;

    fsm_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd.op         = OP_NONE;
        cmd.sub        = 3'd0;
        unique case (state_reg)
            S_INIT0:
            begin
                cmd.op = OP_INIT0;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.op = OP_INIT1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.is_alloc)
                    state_next = sts.zero_req ? S_OUT : S_RD;
                else
                    state_next = sts.free_ok_addr ? S_FR0 : S_OUT;
            end
            S_RD:
            begin
                if (!sts.cur_valid || sts.walk_over)
                    state_next = S_OUT;
                else
                begin
                    cmd.op = OP_RDCUR;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.op = OP_LATCH;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.fits)
                    state_next = sts.split ? S_CARVE0 : S_UNL0;
                else
                begin
                    cmd.op = OP_NEXT;
                    state_next = S_RD;
                end
            end
            S_CARVE0:
            begin
                cmd.op = OP_CARVE_O;
                state_next = S_CARVE1;
            end
            S_CARVE1:
            begin
                cmd.op = OP_CARVE_U;
                state_next = S_CARVE2;
            end
            S_CARVE2:
            begin
                cmd.op = OP_RD_A;
                state_next = S_CARVE3;
            end
            S_CARVE3:
            begin
                cmd.op = OP_LATCH;
                cmd.sub = 3'd1;
                state_next = S_CARVE4;
            end
            S_CARVE4:
            begin
                cmd.op = OP_WR_A_BLEN;
                state_next = S_MARK0;
            end
            S_UNL0:
            begin
                cmd.op = OP_UNLINK;
                cmd.sub = 3'd0;
                state_next = S_UNL1;
            end
            S_UNL1:
            begin
                cmd.op = OP_LATCH;
                cmd.sub = 3'd2;
                state_next = S_UNL2;
            end
            S_UNL2:
            begin
                cmd.op = OP_UNLINK;
                cmd.sub = 3'd1;
                state_next = S_UNL3;
            end
            S_UNL3:
            begin
                cmd.op = OP_LATCH;
                cmd.sub = 3'd3;
                state_next = S_MARK0;
            end
            S_MARK0:
            begin
                cmd.op = OP_RD_TAKEN;
                state_next = S_MARK1;
            end
            S_MARK1:
            begin
                cmd.op = OP_LATCH;
                cmd.sub = 3'd4;
                state_next = S_MARK2;
            end
            S_MARK2:
            begin
                cmd.op = OP_MARK;
                cmd.sub = 3'd0;
                state_next = S_MARK3;
            end
            S_MARK3:
            begin
                cmd.op = OP_MARK;
                cmd.sub = 3'd1;
                state_next = S_OUT;
            end
            S_FR0:
            begin
                cmd.op = OP_FREE;
                cmd.sub = 3'd0;
                state_next = S_FR1;
            end
            S_FR1:
            begin
                cmd.op = OP_LATCH;
                cmd.sub = 3'd4;
                state_next = S_FR2;
            end
            S_FR2:
            begin
                if (sts.tag_free)
                    state_next = S_OUT;
                else
                begin
                    cmd.op = OP_FREE;
                    cmd.sub = 3'd1;
                    state_next = S_FR3;
                end
            end
            S_FR3:
            begin
                cmd.op = OP_FREE;
                cmd.sub = 3'd2;
                state_next = S_FR4;
            end
            S_FR4:
            begin
                cmd.op = OP_LATCH;
                cmd.sub = 3'd1;
                state_next = S_FR5;
            end
            S_FR5:
            begin
                cmd.op = OP_FREE;
                cmd.sub = 3'd3;
                state_next = S_FR6;
            end
            S_FR6:
            begin
                cmd.op = OP_FREE;
                cmd.sub = 3'd4;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.op = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT) |-> !out_valid)
        else $error("result overwrites pending beat");
`endif
endmodule

// ----- src/ffba_dp.sv -----
module ffba_dp #(
    parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffba_pkg::ALIGN_BYTES_DEF
) (
    input  logic                clk,
    input  ffba_pkg::in_beat_t  in_beat,
    output ffba_pkg::out_beat_t out_beat,
    input  ffba_pkg::cmd_t      cmd,
    output ffba_pkg::sts_t      sts,
    input  logic                rst_n
);
    import ffba_pkg::*;

    localparam int AW   = $clog2(ARENA_BYTES / ALIGN_BYTES);
    localparam int SH   = $clog2(ALIGN_BYTES);
    localparam int WALK = ARENA_BYTES / ALIGN_BYTES;
    localparam logic [16:0] ARENA = 17'(ARENA_BYTES);
    localparam logic [16:0] HDR   = 17'(HEADER_BYTES);
    localparam logic [16:0] BODY  = 17'(ARENA_BYTES - 2 * HEADER_BYTES);
    localparam logic [16:0] SENT  = 17'(ARENA_BYTES - HEADER_BYTES);

    tag_t mem [WALK];
    tag_t rd_reg;
    logic [AW-1:0] raddr;
    logic          re;
    logic [AW-1:0] waddr;
    logic          we;
    tag_t          wdata;

    logic          act_reg;
    logic [16:0]   size_reg;
    logic [15:0]   pay_reg;
    logic [16:0]   cur_reg, cur_next;
    logic          head_nil_reg, head_nil_next;
    logic [16:0]   head_reg, head_next;
    logic [AW:0]   cnt_reg, cnt_next;
    tag_t          t_reg, t_next;
    tag_t          a_reg, a_next;
    tag_t          f_reg, f_next;
    logic [16:0]   taken_reg, taken_next;
    logic          found_reg, found_next;
    logic [16:0]   u_off;
    logic [16:0]   rest;
    logic [16:0]   nt_cur;
    logic [16:0]   nt_taken;
    logic [17:0]   fit_end;
    out_beat_t     out_reg;

    function automatic logic [AW-1:0] idx(input logic [16:0] o);
        return o[SH +: AW];
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_reg <= mem[raddr];
    end

    assign rest     = t_reg.len - size_reg - HDR;
    assign u_off    = cur_reg + HDR + rest;
    assign nt_cur   = cur_reg + HDR + t_reg.len;
    assign nt_taken = taken_reg + HDR + t_reg.len;
    assign fit_end  = {1'b0, nt_cur} + {1'b0, HDR};

    always_comb
    begin
        sts.is_alloc     = (act_reg == ACT_ALLOC);
        sts.zero_req     = (size_reg == 17'd0);
        sts.free_ok_addr = (pay_reg != 16'd0) && ({1'b0, pay_reg} >= HDR)
                           && (({1'b0, pay_reg} - HDR) < ARENA);
        sts.cur_valid    = (cur_reg < ARENA);
        sts.walk_over    = (cnt_reg >= (AW+1)'(WALK));
        sts.fits         = (fit_end <= {1'b0, ARENA}) && (t_reg.len >= size_reg + HDR);
        sts.split        = (t_reg.len >= size_reg + HDR + 17'(MIN_REMAINDER));
        sts.tag_free     = t_reg.is_free;
        sts.a_in         = (nt_taken < ARENA);
        sts.f_in         = !t_reg.fwd_nil && (t_reg.fwd < ARENA);
        sts.b_in         = !t_reg.back_nil && (t_reg.back < ARENA);
        sts.head_in      = !head_nil_reg && (head_reg < ARENA);
    end

    always_comb
    begin
        re = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wdata = t_reg;
        cur_next = cur_reg; head_nil_next = head_nil_reg; head_next = head_reg;
        cnt_next = cnt_reg; t_next = t_reg; a_next = a_reg; f_next = f_reg;
        taken_next = taken_reg; found_next = found_reg;
        case (cmd.op)
            OP_INIT0:
            begin
                we = 1'b1; waddr = '0;
                wdata = '{1'b0, 17'd0, 1'b1, BODY, 1'b1, 17'd0, 1'b1, 17'd0};
                head_nil_next = 1'b0; head_next = 17'd0;
            end
            OP_INIT1:
            begin
                we = 1'b1; waddr = idx(SENT);
                wdata = '{1'b1, BODY, 1'b0, 17'd0, 1'b1, 17'd0, 1'b1, 17'd0};
            end
            OP_LOAD:
            begin
                cur_next = head_nil_reg ? ARENA : head_reg;
                cnt_next = '0;
                found_next = 1'b0;
            end
            OP_RDCUR:
            begin
                re = 1'b1; raddr = idx(cur_reg);
            end
            OP_LATCH:
            begin
                case (cmd.sub)
                    3'd0: t_next = rd_reg;
                    3'd1: a_next = rd_reg;
                    3'd2: f_next = rd_reg;
                    3'd3: a_next = rd_reg;
                    default: t_next = rd_reg;
                endcase
            end
            OP_NEXT:
            begin
                cur_next = t_reg.fwd_nil ? ARENA : t_reg.fwd;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_CARVE_O:
            begin
                we = 1'b1; waddr = idx(cur_reg);
                wdata = t_reg; wdata.len = rest;
                taken_next = u_off; found_next = 1'b1;
            end
            OP_CARVE_U:
            begin
                we = 1'b1; waddr = idx(u_off);
                wdata = '{t_reg.is_free, rest, t_reg.is_free, size_reg,
                          1'b1, 17'd0, 1'b1, 17'd0};
            end
            OP_RD_A:
            begin
                re = 1'b1; raddr = idx(u_off + HDR + size_reg);
            end
            OP_WR_A_BLEN:
            begin
                if (u_off + HDR + size_reg < ARENA)
                begin
                    we = 1'b1; waddr = idx(u_off + HDR + size_reg);
                    wdata = a_reg; wdata.below_len = size_reg;
                end
            end
            OP_UNLINK:
            begin
                taken_next = cur_reg; found_next = 1'b1;
                if (cmd.sub == 3'd0)
                begin
                    re = 1'b1; raddr = idx(t_reg.fwd);
                end
                else
                begin
                    re = 1'b1; raddr = idx(t_reg.back);
                    if (sts.f_in)
                    begin
                        we = 1'b1; waddr = idx(t_reg.fwd);
                        wdata = f_reg; wdata.back_nil = t_reg.back_nil;
                        wdata.back = t_reg.back;
                    end
                    if (!sts.b_in)
                    begin
                        head_nil_next = !sts.f_in;
                        head_next = t_reg.fwd;
                    end
                end
            end
            OP_RD_TAKEN:
            begin
                if (sts.b_in && !found_reg)
                    re = 1'b0;
                if (cur_reg == taken_reg && sts.b_in && t_reg.len >= size_reg)
                begin
                    we = 1'b1; waddr = idx(t_reg.back);
                    wdata = a_reg; wdata.fwd_nil = t_reg.fwd_nil; wdata.fwd = t_reg.fwd;
                end
                re = 1'b1; raddr = idx(taken_reg);
            end
            OP_MARK:
            begin
                if (cmd.sub == 3'd0)
                begin
                    we = 1'b1; waddr = idx(taken_reg);
                    wdata = t_reg; wdata.is_free = 1'b0;
                    re = 1'b1; raddr = idx(nt_taken);
                end
                else if (sts.a_in)
                begin
                    we = 1'b1; waddr = idx(nt_taken);
                    wdata = rd_reg; wdata.below_free = 1'b0;
                end
            end
            OP_FREE:
            begin
                case (cmd.sub)
                    3'd0:
                    begin
                        taken_next = {1'b0, pay_reg} - HDR;
                        re = 1'b1; raddr = idx({1'b0, pay_reg} - HDR);
                    end
                    3'd1:
                    begin
                        we = 1'b1; waddr = idx(taken_reg);
                        wdata = t_reg; wdata.is_free = 1'b1;
                        wdata.fwd_nil = head_nil_reg; wdata.fwd = head_reg;
                        wdata.back_nil = 1'b1;
                        re = 1'b1; raddr = idx(nt_taken);
                    end
                    3'd2:
                    begin
                        if (sts.a_in)
                        begin
                            we = 1'b1; waddr = idx(nt_taken);
                            wdata = rd_reg; wdata.below_free = 1'b1;
                        end
                        re = 1'b1; raddr = idx(head_reg);
                    end
                    3'd3:
                    begin
                        if (sts.head_in)
                        begin
                            we = 1'b1; waddr = idx(head_reg);
                            wdata = a_reg; wdata.back_nil = 1'b0;
                            wdata.back = taken_reg;
                            // head tag may be the upper neighbor just marked
                            if (sts.a_in && head_reg == nt_taken)
                                wdata.below_free = 1'b1;
                        end
                    end
                    default:
                    begin
                        head_nil_next = 1'b0; head_next = taken_reg;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_nil_reg <= 1'b0;
            head_reg     <= '0;
        end
        else
        begin
            head_nil_reg <= head_nil_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        t_reg     <= t_next;
        a_reg     <= a_next;
        f_reg     <= f_next;
        taken_reg <= taken_next;
        found_reg <= found_next;
        if (cmd.op == OP_LOAD)
        begin
            act_reg  <= in_beat.action;
            pay_reg  <= in_beat.payload_offset;
            size_reg <= ({1'b0, in_beat.request_bytes} + 17'(ALIGN_BYTES - 1))
                        & ~17'(ALIGN_BYTES - 1);
        end
        if (cmd.op == OP_RESULT)
        begin
            if (act_reg == ACT_FREE)
                out_reg <= '{16'd0, ST_DONE};
            else if (size_reg == 17'd0)
                out_reg <= '{16'd0, ST_ZERO};
            else if (!found_reg)
                out_reg <= '{16'd0, ST_NOFIT};
            else
                out_reg <= '{16'(taken_reg + HDR), ST_DONE};
        end
    end

    assign out_beat = out_reg;
endmodule

// ----- src/first_fit_block_allocator_top.sv -----
// a free with a null or low offset goes straight to the result, a double free
// ends after the tag read; allocate examines free-list blocks in turn and takes a
// whole block or splits one, and a zero-size request goes straight to the result
// throughput: one beat at a time, next beat taken the cycle after the result registers
// reset: asynchronous active low; after reset states S_INIT0 and S_INIT1 write the initial block
// and end sentinel tags before the first input beat is taken
module first_fit_block_allocator_top #(
    parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffba_pkg::ALIGN_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffba_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffba_pkg::out_beat_t out_data
);
    import ffba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
    );

    ffba_dp #(
        .ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES),
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_dp (
        .clk(clk), .in_beat(in_data), .out_beat(out_data),
        .cmd(cmd), .sts(sts), .rst_n(rst_n)
    );
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int unsigned ARENA    = ARENA_BYTES_DEF;
    localparam int unsigned HDR      = HEADER_BYTES_DEF;
    localparam int unsigned ALIGN    = ALIGN_BYTES_DEF;
    localparam int unsigned NO_BLOCK = 32'hFFFF_FFFF;
    localparam int unsigned WALK_MAX = ARENA / ALIGN;
    localparam int unsigned LIMIT    = 10_000_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    first_fit_block_allocator_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #1 clk = ~clk;

    // allocator state mirror
    bit          tag_bfree [ARENA];
    int unsigned tag_blen [ARENA];
    bit          tag_free [ARENA];
    int unsigned tag_len [ARENA];
    int unsigned tag_fwd [ARENA];
    int unsigned tag_back [ARENA];
    int unsigned list_head;

    out_beat_t   grant_q[$];
    logic [15:0] live_q[$];
    int unsigned known_tags[$];
    int          errors = 0;
    int          beats_sent = 0;
    int          beats_checked = 0;
    int          grants = 0;
    int          nofits = 0;
    int unsigned cycles = 0;
    int          wait_cnt = 0;
    bit          quiet = 1'b0;

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic void reset_arena();
        int unsigned s;
        s = ARENA - HDR;
        list_head = 0;
        tag_bfree[0] = 0; tag_blen[0] = 0; tag_free[0] = 1;
        tag_len[0] = ARENA - 2 * HDR; tag_fwd[0] = NO_BLOCK; tag_back[0] = NO_BLOCK;
        tag_bfree[s] = 1; tag_blen[s] = ARENA - 2 * HDR; tag_free[s] = 0;
        tag_len[s] = 0; tag_fwd[s] = NO_BLOCK; tag_back[s] = NO_BLOCK;
        known_tags.push_back(0);
    endfunction

    function automatic void detach_block(int unsigned o);
        int unsigned f, b;
        f = tag_fwd[o];
        b = tag_back[o];
        if (f < ARENA) tag_back[f] = b;
        if (b < ARENA) tag_fwd[b] = f;
        else list_head = (f < ARENA) ? f : NO_BLOCK;
    endfunction

    function automatic int unsigned split_upper(int unsigned o, int unsigned size);
        int unsigned rest, u, a;
        rest = tag_len[o] - (size + HDR);
        tag_len[o] = rest;
        u = o + HDR + rest;
        tag_blen[u] = rest;
        tag_bfree[u] = tag_free[o];
        tag_len[u] = size;
        tag_free[u] = tag_free[o];
        known_tags.push_back(u);
        a = u + HDR + size;
        if (a < ARENA) tag_blen[a] = size;
        return u;
    endfunction

    function automatic out_beat_t alloc_free_step(in_beat_t b);
        out_beat_t   r;
        int unsigned size, cur, taken, a, n, blk;
        r = '0;
        taken = NO_BLOCK;
        n = 0;
        if (b.action == ACT_ALLOC) begin
            if (b.request_bytes == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            size = ((int'(b.request_bytes) + ALIGN - 1) / ALIGN) * ALIGN;
            cur = list_head;
            while (cur < ARENA && n < WALK_MAX) begin
                if (cur + HDR + tag_len[cur] + HDR <= ARENA && tag_len[cur] >= size + HDR) begin
                    if (tag_len[cur] >= size + HDR + MIN_REMAINDER)
                        taken = split_upper(cur, size);
                    else begin
                        detach_block(cur);
                        taken = cur;
                    end
                    break;
                end
                cur = tag_fwd[cur];
                n++;
            end
            if (taken >= ARENA) begin
                r.status = ST_NOFIT;
                return r;
            end
            tag_free[taken] = 0;
            a = taken + HDR + tag_len[taken];
            if (a < ARENA) tag_bfree[a] = 0;
            r.grant_offset = 16'(taken + HDR);
            r.status = ST_DONE;
            return r;
        end
        if (b.payload_offset != 0 && b.payload_offset >= HDR) begin
            blk = int'(b.payload_offset) - HDR;
            if (blk < ARENA && !tag_free[blk]) begin
                tag_free[blk] = 1;
                a = blk + HDR + tag_len[blk];
                if (a < ARENA) tag_bfree[a] = 1;
                tag_fwd[blk] = list_head;
                tag_back[blk] = NO_BLOCK;
                if (list_head < ARENA) tag_back[list_head] = blk;
                list_head = blk;
            end
        end
        r.status = ST_DONE;
        return r;
    endfunction

    task automatic send_beat(input logic act, input logic [15:0] req, input logic [15:0] pay);
        in_beat_t  b;
        out_beat_t r;
        int        gap;
        b.action = act;
        b.request_bytes = req;
        b.payload_offset = pay;
        in_data <= b;
        in_valid <= 1'b1;
        @(posedge clk iff !in_stall);
        r = alloc_free_step(b);
        grant_q.push_back(r);
        beats_sent++;
        if (act == ACT_ALLOC && r.status == ST_DONE) begin
            live_q.push_back(r.grant_offset);
            grants++;
        end
        if (act == ACT_ALLOC && r.status == ST_NOFIT) nofits++;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic alloc_beat(input logic [15:0] req);
        send_beat(ACT_ALLOC, req, 16'($urandom()));
    endtask

    task automatic free_beat(input logic [15:0] pay);
        send_beat(ACT_FREE, 16'($urandom()), pay);
    endtask

    task automatic free_live();
        int          i;
        logic [15:0] p;
        i = $urandom_range(0, live_q.size() - 1);
        p = live_q[i];
        live_q.delete(i);
        free_beat(p);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, beats_checked);
        errors++;
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_beat_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (grant_q.size() == 0) begin
                    report("unexpected beat", out_data.grant_offset, 0);
                end
                else begin
                    want = grant_q.pop_front();
                    if (out_data.grant_offset !== want.grant_offset)
                        report("grant_offset", out_data.grant_offset, want.grant_offset);
                    if (out_data.status !== want.status)
                        report("status", out_data.status, want.status);
                end
                beats_checked++;
                wait_cnt = draw_wait();
            end
            else if (wait_cnt > 0) begin
                wait_cnt--;
            end
            out_stall <= (wait_cnt > 0);
        end
    end

    task automatic test_edge_requests();
        alloc_beat(16'd0);
        alloc_beat(16'd1);
        alloc_beat(16'd8);
        alloc_beat(16'd9);
        alloc_beat(16'hFFFF);
        alloc_beat(16'd65465);
        alloc_beat(16'd200);
    endtask

    task automatic test_free_cases();
        free_beat(16'd0);
        free_beat(16'd1);
        free_beat(16'd23);
        free_beat(16'(HDR));
        free_live();
        free_beat(live_q.size() > 0 ? live_q[0] : 16'd0);
        free_beat(live_q.size() > 0 ? live_q[0] : 16'd0);
    endtask

    task automatic test_whole_block_reuse();
        logic [15:0] p;
        alloc_beat(16'd40);
        p = live_q[$];
        live_q.delete(live_q.size() - 1);
        free_beat(p);
        alloc_beat(16'd16);
        alloc_beat(16'd33);
    endtask

    task automatic test_fill_arena();
        int k;
        quiet = 1'b1;
        k = 0;
        while (nofits == 0 || k < 2) begin
            alloc_beat(16'd6000);
            if (grant_q[$].status == ST_NOFIT) k++;
        end
        alloc_beat(16'd5000);
        quiet = 1'b0;
        while (live_q.size() > 4) free_live();
    endtask

    task automatic test_random_traffic(input int count);
        int i, pick;
        for (i = 0; i < count; i++) begin
            if (i % 200 == 150) quiet = 1'b1;
            if (i % 200 == 190) quiet = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                alloc_beat(16'($urandom_range(1, 300)));
            else if (pick < 50)
                alloc_beat(16'($urandom()));
            else if (pick < 53)
                alloc_beat(16'd0);
            else if (pick < 85 && live_q.size() > 0)
                free_live();
            else if (pick < 93)
                free_beat(16'(known_tags[$urandom_range(0, known_tags.size() - 1)] + HDR));
            else
                free_beat(16'($urandom_range(0, HDR - 1)));
        end
    endtask

    initial begin
        reset_arena();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_requests();
        test_free_cases();
        test_whole_block_reuse();
        test_fill_arena();
        test_random_traffic(800);
        in_valid <= 1'b0;
        while (grant_q.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("sent %0d beats, checked %0d results: %0d grants, %0d no-fit refusals",
                 beats_sent, beats_checked, grants, nofits);
        $display("covered zero-size, null, low and double frees, splits and whole-block reuse");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
